FILE: rtl/core/rqmpt_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rqmpt_pkg: shared types and codes for the ready-queue slot table
// Holds the status codes, action codes and fixed field widths of the stream
// ports.
// ----------------------------------------------------------------------------
package rqmpt_pkg;

    // Field widths on the stream ports
    localparam int ID_W       = 16;
    localparam int PRIO_W     = 8;
    localparam int STAT_W     = 2;
    localparam int OCC_W      = 6;
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 32;

    typedef logic [STAT_W-1:0] t_status;

    // Status codes
    localparam t_status STAT_DONE  = 2'd0;
    localparam t_status STAT_FULL  = 2'd1;
    localparam t_status STAT_BADID = 2'd2;
    localparam t_status STAT_EMPTY = 2'd3;

    // Request kinds
    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_REMOVE = 1'b1;

endpackage : rqmpt_pkg
`default_nettype wire

FILE: rtl/core/ready_queue_min_priority_table.sv
`default_nettype none
// A request that scans walks the slot store one entry a cycle over its read port,
//   then the wrap and finish states; finish waits for room in the output register.
// Requests refused up front (table full, id zero, table empty) go straight to the finish state.
// One request in flight: a new request is accepted only after the result is committed.
// Reset (i_rst_n low, synchronous) clears all slot valid bits and the occupancy;
//   the slot store itself is not cleared and holds no meaning until written.
// ----------------------------------------------------------------------------
// ready_queue_min_priority_table: scheduler ready queue over a slot table
// Insert fills the first free slot with an id and priority; remove frees the
// valid slot with the smallest priority (the later slot on a tie).
// ----------------------------------------------------------------------------
module ready_queue_min_priority_table #(
    parameter int SLOTS     = 32,
    parameter int ID_BITS   = 16,
    parameter int PRIO_BITS = 8
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // request stream
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    input  wire logic [rqmpt_pkg::IN_DATA_W-1:0]   s_axis_tdata,  // proc_id, proc_priority
    input  wire logic                              s_axis_tuser,  // action
    // result stream
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    output logic      [rqmpt_pkg::OUT_DATA_W-1:0]  m_axis_tdata   // status, removed_id,
                                                                  // removed_priority, occupancy
);

    import rqmpt_pkg::*;

    localparam int IDX_W = $clog2(SLOTS);
    localparam int CNT_W = $clog2(SLOTS + 1);

    // request fields, cut to the stored widths
    logic [ID_W-1:0]      in_id_field;
    logic [PRIO_W-1:0]    in_prio_field;
    logic [ID_BITS-1:0]   req_id;
    logic [PRIO_BITS-1:0] req_prio;

    // slot store port
    logic                 ram_we;
    logic [IDX_W-1:0]     ram_waddr;
    logic [ID_BITS-1:0]   ram_wid;
    logic [PRIO_BITS-1:0] ram_wprio;
    logic [IDX_W-1:0]     ram_raddr;
    logic [ID_BITS-1:0]   ram_rid;
    logic [PRIO_BITS-1:0] ram_rprio;

    // committed result from the sequencer
    logic                 res_valid;
    t_status              res_status;
    logic [ID_BITS-1:0]   res_id;
    logic [PRIO_BITS-1:0] res_prio;
    logic [CNT_W-1:0]     res_count;
    logic                 res_room;

    // output register
    logic                  r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;

    assign in_id_field   = s_axis_tdata[ID_W-1:0];
    assign in_prio_field = s_axis_tdata[ID_W +: PRIO_W];
    assign req_id        = ID_BITS'(in_id_field);
    assign req_prio      = PRIO_BITS'(in_prio_field);

    rqmpt_slot_ram #(
        .SLOTS     (SLOTS),
        .ID_BITS   (ID_BITS),
        .PRIO_BITS (PRIO_BITS),
        .IDX_W     (IDX_W)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wid   (ram_wid),
        .i_wprio (ram_wprio),
        .i_raddr (ram_raddr),
        .o_rid   (ram_rid),
        .o_rprio (ram_rprio)
    );

    rqmpt_ctrl #(
        .SLOTS     (SLOTS),
        .ID_BITS   (ID_BITS),
        .PRIO_BITS (PRIO_BITS),
        .IDX_W     (IDX_W),
        .CNT_W     (CNT_W)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_valid  (s_axis_tvalid),
        .o_req_ready  (s_axis_tready),
        .i_action     (s_axis_tuser),
        .i_id         (req_id),
        .i_prio       (req_prio),
        .o_ram_we     (ram_we),
        .o_ram_waddr  (ram_waddr),
        .o_ram_wid    (ram_wid),
        .o_ram_wprio  (ram_wprio),
        .o_ram_raddr  (ram_raddr),
        .i_ram_rid    (ram_rid),
        .i_ram_rprio  (ram_rprio),
        .i_res_room   (res_room),
        .o_res_valid  (res_valid),
        .o_res_status (res_status),
        .o_res_id     (res_id),
        .o_res_prio   (res_prio),
        .o_res_count  (res_count)
    );

    // Commit a result only when the output register is free or drains this cycle.
    assign res_room = !r_out_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
        if (res_valid) begin
            // pack from the lowest bit: status, id, priority, occupancy
            r_out_data <= {OCC_W'(res_count), PRIO_W'(res_prio),
                           ID_W'(res_id), res_status};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // One request in flight: the request port closes right after an accept.
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("request accepted while another is in flight");

    // An empty-table result carries no removed process and zero occupancy.
    a_empty_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tdata[STAT_W-1:0] == STAT_EMPTY)) |->
        (m_axis_tdata[OUT_DATA_W-1:STAT_W] == '0))
        else $error("empty status with nonzero payload");

    // A full-table refusal reports the table at capacity.
    a_full_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tdata[STAT_W-1:0] == STAT_FULL)) |->
        (m_axis_tdata[OUT_DATA_W-1 -: OCC_W] == OCC_W'(SLOTS)))
        else $error("full status without full occupancy");

    // A result is committed only into a free or draining output register.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_valid |-> (!r_out_valid || m_axis_tready))
        else $error("result overwrote a pending output");

endmodule : ready_queue_min_priority_table
`default_nettype wire

FILE: rtl/core/rqmpt_slot_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rqmpt_slot_ram: slot id and priority store
// One write port and one read port; read data registered.
// ----------------------------------------------------------------------------
module rqmpt_slot_ram #(
    parameter int SLOTS     = 32,
    parameter int ID_BITS   = 16,
    parameter int PRIO_BITS = 8,
    parameter int IDX_W     = $clog2(SLOTS)
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_we,
    input  wire logic [IDX_W-1:0]     i_waddr,
    input  wire logic [ID_BITS-1:0]   i_wid,
    input  wire logic [PRIO_BITS-1:0] i_wprio,
    input  wire logic [IDX_W-1:0]     i_raddr,
    output logic      [ID_BITS-1:0]   o_rid,
    output logic      [PRIO_BITS-1:0] o_rprio
);

    logic [ID_BITS-1:0]   r_id_mem   [SLOTS];
    logic [PRIO_BITS-1:0] r_prio_mem [SLOTS];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_id_mem[i_waddr]   <= i_wid;
            r_prio_mem[i_waddr] <= i_wprio;
        end
        o_rid   <= r_id_mem[i_raddr];
        o_rprio <= r_prio_mem[i_raddr];
    end

endmodule : rqmpt_slot_ram
`default_nettype wire

FILE: rtl/core/rqmpt_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rqmpt_ctrl: scan sequencer for insert and remove requests
// Walks the slot store one entry a cycle, tracks duplicate, first free slot
// and minimum priority, then commits the write-back and the result.
// ----------------------------------------------------------------------------
module rqmpt_ctrl #(
    parameter int SLOTS     = 32,
    parameter int ID_BITS   = 16,
    parameter int PRIO_BITS = 8,
    parameter int IDX_W     = $clog2(SLOTS),
    parameter int CNT_W     = $clog2(SLOTS + 1)
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // request side
    input  wire logic                 i_req_valid,
    output logic                      o_req_ready,
    input  wire logic                 i_action,
    input  wire logic [ID_BITS-1:0]   i_id,
    input  wire logic [PRIO_BITS-1:0] i_prio,
    // slot store
    output logic                      o_ram_we,
    output logic      [IDX_W-1:0]     o_ram_waddr,
    output logic      [ID_BITS-1:0]   o_ram_wid,
    output logic      [PRIO_BITS-1:0] o_ram_wprio,
    output logic      [IDX_W-1:0]     o_ram_raddr,
    input  wire logic [ID_BITS-1:0]   i_ram_rid,
    input  wire logic [PRIO_BITS-1:0] i_ram_rprio,
    // result side
    input  wire logic                 i_res_room,
    output logic                      o_res_valid,
    output rqmpt_pkg::t_status        o_res_status,
    output logic      [ID_BITS-1:0]   o_res_id,
    output logic      [PRIO_BITS-1:0] o_res_prio,
    output logic      [CNT_W-1:0]     o_res_count
);

    import rqmpt_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_WRAP,
        S_FINISH
    } t_state;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(SLOTS);

    t_state                r_state,       n_state;
    logic                  r_action,      n_action;
    logic [ID_BITS-1:0]    r_id,          n_id;
    logic [PRIO_BITS-1:0]  r_prio,        n_prio;
    logic [IDX_W-1:0]      r_idx,         n_idx;
    logic                  r_rd_vld,      n_rd_vld;
    logic [IDX_W-1:0]      r_rd_idx,      n_rd_idx;
    logic                  r_dup,         n_dup;
    logic                  r_free_found,  n_free_found;
    logic [IDX_W-1:0]      r_free_idx,    n_free_idx;
    logic                  r_best_found,  n_best_found;
    logic [IDX_W-1:0]      r_best_idx,    n_best_idx;
    logic [ID_BITS-1:0]    r_best_id,     n_best_id;
    logic [PRIO_BITS-1:0]  r_best_prio,   n_best_prio;
    logic                  r_skip,        n_skip;
    t_status               r_skip_status, n_skip_status;
    logic [SLOTS-1:0]      r_valid,       n_valid;
    logic [CNT_W-1:0]      r_count,       n_count;
    logic                  r_res_valid,   n_res_valid;
    t_status               r_res_status,  n_res_status;
    logic [ID_BITS-1:0]    r_res_id,      n_res_id;
    logic [PRIO_BITS-1:0]  r_res_prio,    n_res_prio;

    logic slot_v;
    logic ins_commit;

    assign slot_v     = r_valid[r_rd_idx];
    assign ins_commit = (r_state == S_FINISH) && i_res_room && !r_skip
                        && (r_action == ACT_INSERT) && !r_dup;

    always_comb begin
        n_state       = r_state;
        n_action      = r_action;
        n_id          = r_id;
        n_prio        = r_prio;
        n_idx         = r_idx;
        n_rd_vld      = 1'b0;
        n_rd_idx      = r_idx;
        n_dup         = r_dup;
        n_free_found  = r_free_found;
        n_free_idx    = r_free_idx;
        n_best_found  = r_best_found;
        n_best_idx    = r_best_idx;
        n_best_id     = r_best_id;
        n_best_prio   = r_best_prio;
        n_skip        = r_skip;
        n_skip_status = r_skip_status;
        n_valid       = r_valid;
        n_count       = r_count;
        n_res_valid   = 1'b0;
        n_res_status  = r_res_status;
        n_res_id      = r_res_id;
        n_res_prio    = r_res_prio;

        // fold in the entry read last cycle
        if (r_rd_vld) begin
            if (r_action == ACT_INSERT) begin
                if (slot_v && (i_ram_rid == r_id)) begin
                    n_dup = 1'b1;
                end
                if (!slot_v && !r_free_found) begin
                    n_free_found = 1'b1;
                    n_free_idx   = r_rd_idx;
                end
            end else if (slot_v && (!r_best_found || (i_ram_rprio <= r_best_prio))) begin
                n_best_found = 1'b1;
                n_best_idx   = r_rd_idx;
                n_best_id    = i_ram_rid;
                n_best_prio  = i_ram_rprio;
            end
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    n_action      = i_action;
                    n_id          = i_id;
                    n_prio        = i_prio;
                    n_idx         = '0;
                    n_dup         = 1'b0;
                    n_free_found  = 1'b0;
                    n_best_found  = 1'b0;
                    n_skip        = 1'b1;
                    n_skip_status = STAT_DONE;
                    n_state       = S_FINISH;
                    if (i_action == ACT_INSERT) begin
                        // fullness is checked before the id
                        if (r_count >= FULL_CNT) begin
                            n_skip_status = STAT_FULL;
                        end else if (i_id == '0) begin
                            n_skip_status = STAT_BADID;
                        end else begin
                            n_skip  = 1'b0;
                            n_state = S_SCAN;
                        end
                    end else begin
                        if (r_count == '0) begin
                            n_skip_status = STAT_EMPTY;
                        end else begin
                            n_skip  = 1'b0;
                            n_state = S_SCAN;
                        end
                    end
                end
            end
            S_SCAN: begin
                n_rd_vld = 1'b1;
                n_rd_idx = r_idx;
                n_idx    = r_idx + 1'b1;
                if (r_idx == LAST_IDX) begin
                    n_state = S_WRAP;
                end
            end
            S_WRAP: begin
                n_state = S_FINISH;
            end
            S_FINISH: begin
                if (i_res_room) begin
                    n_res_valid = 1'b1;
                    n_res_id    = '0;
                    n_res_prio  = '0;
                    n_state     = S_IDLE;
                    if (r_skip) begin
                        n_res_status = r_skip_status;
                    end else if (r_action == ACT_INSERT) begin
                        if (r_dup) begin
                            n_res_status = STAT_BADID;
                        end else begin
                            n_res_status          = STAT_DONE;
                            n_valid[r_free_idx]   = 1'b1;
                            n_count               = r_count + 1'b1;
                        end
                    end else begin
                        n_res_status        = STAT_DONE;
                        n_res_id            = r_best_id;
                        n_res_prio          = r_best_prio;
                        n_valid[r_best_idx] = 1'b0;
                        n_count             = r_count - 1'b1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_rd_vld    <= 1'b0;
            r_valid     <= '0;
            r_count     <= '0;
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_rd_vld    <= n_rd_vld;
            r_valid     <= n_valid;
            r_count     <= n_count;
            r_res_valid <= n_res_valid;
        end
        r_action      <= n_action;
        r_id          <= n_id;
        r_prio        <= n_prio;
        r_idx         <= n_idx;
        r_rd_idx      <= n_rd_idx;
        r_dup         <= n_dup;
        r_free_found  <= n_free_found;
        r_free_idx    <= n_free_idx;
        r_best_found  <= n_best_found;
        r_best_idx    <= n_best_idx;
        r_best_id     <= n_best_id;
        r_best_prio   <= n_best_prio;
        r_skip        <= n_skip;
        r_skip_status <= n_skip_status;
        r_res_status  <= n_res_status;
        r_res_id      <= n_res_id;
        r_res_prio    <= n_res_prio;
    end

    assign o_req_ready  = (r_state == S_IDLE);
    assign o_ram_we     = ins_commit;
    assign o_ram_waddr  = r_free_idx;
    assign o_ram_wid    = r_id;
    assign o_ram_wprio  = r_prio;
    assign o_ram_raddr  = r_idx;
    assign o_res_valid  = r_res_valid;
    assign o_res_status = r_res_status;
    assign o_res_id     = r_res_id;
    assign o_res_prio   = r_res_prio;
    assign o_res_count  = r_count;

endmodule : rqmpt_ctrl
`default_nettype wire

FILE: tb/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for the ready-queue slot table
// Sends insert and remove requests over the request stream. A shadow copy of
// the slot table predicts the status, removed id and priority, and the
// occupancy for each request. Each result on the result stream is checked
// field by field, with random source gaps and sink stalls throughout.
// ----------------------------------------------------------------------------
module tb;
    import rqmpt_pkg::*;

    localparam int NSLOTS      = 32;
    localparam int CYCLE_LIMIT = 600000;  // watchdog bound on the run length
    localparam int LONG_HOLD   = 400;     // sink hold-off used by the back-pressure test
    localparam int TAIL_CYCLES = 60;      // longer than one full scan of the slots
    localparam int MAX_REPORTS = 10;

    // Result fields, highest bits first, so the struct overlays m_axis_tdata
    typedef struct packed {
        logic [OCC_W-1:0]  occ;
        logic [PRIO_W-1:0] rprio;
        logic [ID_W-1:0]   rid;
        t_status           status;
    } t_outcome;

    // Sink behavior, switched to a random mode at the end of each phase
    typedef enum int {SINK_OPEN, SINK_COIN, SINK_SPARSE, SINK_PERIODIC} t_sink_mode;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;          // proc_id, proc_priority
    logic                  s_axis_tuser  = ACT_INSERT;  // action
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;                // status, removed_id,
                                                        // removed_priority, occupancy

    // Shadow slot table, updated as each request is accepted
    logic              shadow_valid [NSLOTS];
    logic [ID_W-1:0]   shadow_id    [NSLOTS];
    logic [PRIO_W-1:0] shadow_prio  [NSLOTS];
    int unsigned       shadow_count;

    // Results still owed by the block, oldest first
    t_outcome pending_outcomes [$];

    int burst_left  = 0;
    int hold_asks   = 0;
    int fail_count  = 0;
    int n_requests  = 0;
    int n_results   = 0;
    int n_in_stall  = 0;
    int n_status [4] = '{default: 0};

    ready_queue_min_priority_table #(
        .SLOTS     (NSLOTS),
        .ID_BITS   (ID_W),
        .PRIO_BITS (PRIO_W)
    ) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Apply one accepted request to the shadow table and return the result it
    // must produce. Fullness wins over the id check; only valid slots count as
    // duplicates; on equal priority the later slot is removed.
    function automatic t_outcome schedule_outcome(logic act, logic [ID_W-1:0] id,
                                                  logic [PRIO_W-1:0] prio);
        t_outcome res;
        int       best;
        int       free_slot;
        bit       dup;
        res       = '0;
        best      = -1;
        free_slot = -1;
        dup       = 1'b0;
        if (act == ACT_INSERT) begin
            if (shadow_count >= NSLOTS) begin
                res.status = STAT_FULL;
            end else begin
                for (int i = 0; i < NSLOTS; i++) begin
                    if (shadow_valid[i] && shadow_id[i] == id)
                        dup = 1'b1;
                    if (!shadow_valid[i] && free_slot < 0)
                        free_slot = i;
                end
                if (id == '0 || dup) begin
                    res.status = STAT_BADID;
                end else begin
                    shadow_valid[free_slot] = 1'b1;
                    shadow_id[free_slot]    = id;
                    shadow_prio[free_slot]  = prio;
                    shadow_count++;
                    res.status = STAT_DONE;
                end
            end
        end else begin
            for (int i = 0; i < NSLOTS; i++) begin
                if (shadow_valid[i] && (best < 0 || shadow_prio[i] <= shadow_prio[best]))
                    best = i;
            end
            if (best < 0) begin
                res.status = STAT_EMPTY;
            end else begin
                res.rid            = shadow_id[best];
                res.rprio          = shadow_prio[best];
                shadow_valid[best] = 1'b0;
                shadow_count--;
                res.status = STAT_DONE;
            end
        end
        res.occ = shadow_count[OCC_W-1:0];
        return res;
    endfunction

    // Offer one request at a falling edge and hold it until accepted. Start a
    // new burst with a random gap in front of it when the current one is used up.
    task automatic send_request(logic act, logic [ID_W-1:0] id, logic [PRIO_W-1:0] prio);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 30) : $urandom_range(0, 3);
            if (gap > 0) begin
                @(negedge i_clk);
                s_axis_tvalid = 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
        end
        burst_left--;
        @(negedge i_clk);
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = act;
        s_axis_tdata  = {prio, id};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        pending_outcomes.push_back(schedule_outcome(act, id, prio));
        n_requests++;
    endtask

    // Insert with an id mostly from a small pool so duplicates happen, now and
    // then a zero id or a full-width one; priorities often tie.
    task automatic offer_insert(int pool_hi);
        logic [ID_W-1:0]   id;
        logic [PRIO_W-1:0] prio;
        int                r;
        r = $urandom_range(0, 99);
        if (r < 5)
            id = '0;
        else if (r < 30)
            id = ID_W'($urandom());
        else
            id = ID_W'($urandom_range(1, pool_hi));
        prio = $urandom_range(0, 1) ? PRIO_W'($urandom_range(0, 3)) : PRIO_W'($urandom());
        send_request(ACT_INSERT, id, prio);
    endtask

    // Remove; the data fields are ignored by the block, so fill them with noise
    task automatic offer_remove();
        send_request(ACT_REMOVE, ID_W'($urandom()), PRIO_W'($urandom()));
    endtask

    task automatic offer_mixed(int insert_pct);
        if ($urandom_range(0, 99) < insert_pct)
            offer_insert(64);
        else
            offer_remove();
    endtask

    // Drop valid and hold until every owed result has come back
    task automatic wait_drained();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (pending_outcomes.size() != 0) @(posedge i_clk);
    endtask

    // Extremes of the fields, refusals on an empty table, priority ties and
    // reuse of a freed slot.
    task automatic test_directed();
        offer_remove();                                   // remove from an empty table
        send_request(ACT_INSERT, 16'h0000, 8'h12);        // reserved id
        send_request(ACT_INSERT, 16'hFFFF, 8'hFF);        // top id, top priority
        send_request(ACT_INSERT, 16'h0001, 8'h00);
        send_request(ACT_INSERT, 16'hFFFF, 8'h00);        // duplicate id
        send_request(ACT_INSERT, 16'h0002, 8'h00);        // ties with id 1
        send_request(ACT_INSERT, 16'h0003, 8'hFF);        // ties with the top id
        offer_remove();                                   // later of the zero-priority pair
        offer_remove();
        offer_remove();                                   // later of the 0xFF pair
        send_request(ACT_INSERT, 16'h0002, 8'h55);        // reuse a removed id, first free slot
        send_request(ACT_INSERT, 16'h8000, 8'h80);
        send_request(ACT_INSERT, 16'h7FFF, 8'h7F);
        send_request(ACT_INSERT, 16'hAAAA, 8'hAA);
        send_request(ACT_INSERT, 16'h5555, 8'h55);        // ties with id 2 from a later slot
        repeat (7) offer_remove();                        // drain, then one past empty
        wait_drained();
    endtask

    // Fill every slot, try refused inserts on a full table (a zero id must
    // still read as full), refill a freed slot, then drain past empty.
    task automatic test_full_slots();
        for (int i = 0; i < NSLOTS; i++)
            send_request(ACT_INSERT, ID_W'(16'h1000 + i), PRIO_W'($urandom()));
        send_request(ACT_INSERT, 16'h0000, 8'h01);
        send_request(ACT_INSERT, 16'h1000, 8'h01);
        send_request(ACT_INSERT, 16'hBEEF, 8'h01);
        offer_remove();
        send_request(ACT_INSERT, 16'hBEEF, 8'h00);
        repeat (NSLOTS + 1) offer_remove();
        wait_drained();
    endtask

    task automatic test_random_mix(int count);
        repeat (count) offer_mixed(55);
    endtask

    // Fill and drain sweeps with random content, so that the
    // table spends time near both ends of its occupancy.
    task automatic test_fill_drain(int rounds);
        int guard;
        repeat (rounds) begin
            guard = 0;
            while (shadow_count < NSLOTS && guard < 300) begin
                if ($urandom_range(0, 99) < 85) offer_insert(96); else offer_remove();
                guard++;
            end
            repeat ($urandom_range(1, 4)) offer_insert(96);
            guard = 0;
            while (shadow_count > 0 && guard < 300) begin
                if ($urandom_range(0, 99) < 85) offer_remove(); else offer_insert(96);
                guard++;
            end
            repeat ($urandom_range(1, 3)) offer_remove();
        end
    endtask

    // Ask the sink for a long hold-off and keep offering requests, so the
    // block stalls its input behind the held result.
    task automatic test_backpressure(int count);
        hold_asks++;
        repeat (count) offer_mixed(60);
    endtask

    // Send short runs and let the block go fully idle between them
    task automatic test_quiesce(int runs);
        repeat (runs) begin
            repeat ($urandom_range(10, 40)) offer_mixed(55);
            wait_drained();
            repeat ($urandom_range(1, 40)) @(posedge i_clk);
        end
    endtask

    // Sink: long hold-off on request, otherwise a pattern that changes mode
    initial begin
        int         hold_seen;
        int         hold_left;
        int         phase_left;
        int         tick;
        t_sink_mode mode;
        hold_seen  = 0;
        hold_left  = 0;
        phase_left = 0;
        tick       = 0;
        mode       = SINK_OPEN;
        forever begin
            @(negedge i_clk);
            tick++;
            if (hold_asks != hold_seen) begin
                hold_seen = hold_asks;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready = 1'b0;
            end else begin
                if (phase_left == 0) begin
                    mode       = t_sink_mode'($urandom_range(0, 3));
                    phase_left = $urandom_range(20, 300);
                end
                phase_left--;
                case (mode)
                    SINK_OPEN:     m_axis_tready = 1'b1;
                    SINK_COIN:     m_axis_tready = 1'($urandom_range(0, 1));
                    SINK_SPARSE:   m_axis_tready = ($urandom_range(0, 3) == 0);
                    default:       m_axis_tready = (tick % 5 != 0);
                endcase
            end
        end
    end

    // Check every accepted result against the oldest owed one
    initial begin
        t_outcome want;
        t_outcome got;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && s_axis_tvalid && !s_axis_tready)
                n_in_stall++;
            if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
                got = t_outcome'(m_axis_tdata);
                n_results++;
                if (pending_outcomes.size() == 0) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display("result %0d with nothing owed: tdata %h", n_results,
                                 m_axis_tdata);
                end else begin
                    want = pending_outcomes.pop_front();
                    n_status[want.status]++;
                    if (got.status !== want.status || got.rid !== want.rid ||
                        got.rprio !== want.rprio || got.occ !== want.occ) begin
                        fail_count++;
                        if (fail_count <= MAX_REPORTS)
                            $display({"result %0d mismatch: status %0d/%0d id %h/%h ",
                                      "prio %h/%h occ %0d/%0d (expected/actual)"},
                                     n_results, want.status, got.status, want.rid, got.rid,
                                     want.rprio, got.rprio, want.occ, got.occ);
                    end
                end
            end
        end
    end

    // Watchdog: end the run as failed if it outlasts CYCLE_LIMIT
    initial begin
        int unsigned cycles;
        cycles = 0;
        while (cycles <= CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("timeout after %0d cycles, %0d results owed", cycles,
                 pending_outcomes.size());
        $display("ready_queue_min_priority_table test failed");
        $finish;
    end

    initial begin
        foreach (shadow_valid[i]) begin
            shadow_valid[i] = 1'b0;
            shadow_id[i]    = '0;
            shadow_prio[i]  = '0;
        end
        shadow_count = 0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        test_full_slots();
        test_random_mix(450);
        test_fill_drain(9);
        test_backpressure(60);
        test_quiesce(4);
        test_random_mix(150);

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("%0d requests, %0d results: %0d done, %0d full, %0d bad id, %0d empty",
                 n_requests, n_results, n_status[STAT_DONE], n_status[STAT_FULL],
                 n_status[STAT_BADID], n_status[STAT_EMPTY]);
        $display("input held off for %0d cycles, %0d mismatches", n_in_stall, fail_count);
        if (fail_count == 0 && pending_outcomes.size() == 0) begin
            $display("ready_queue_min_priority_table test passed");
        end else begin
            $display("ready_queue_min_priority_table test failed");
        end
        $finish;
    end

endmodule
